>>> design/multichannel_block_peak_framer_macros.svh
// assertion helpers shared by the rtl files
`ifndef MULTICHANNEL_BLOCK_PEAK_FRAMER_MACROS_SVH
`define MULTICHANNEL_BLOCK_PEAK_FRAMER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MBPF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mbpf assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define MBPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mbpf assertion failed");

`endif

>>> design/mbpf_pkg.sv
`default_nettype none
package mbpf_pkg;

  localparam int NUM_IN       = 12;
  localparam int SAMPLE_W     = 12;
  localparam int IN_W         = NUM_IN * SAMPLE_W;
  localparam int BYTE_W       = 8;

  localparam int BLOCK_LEN_DEF = 10;
  localparam int CHANNELS_DEF  = 12;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [BYTE_W-1:0]   HDR_BYTE     = 8'h0A;
  localparam logic [BYTE_W-1:0]   TRL_BYTE     = 8'h0B;
  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 12'd3900;

endpackage
`default_nettype wire

>>> design/mbpf_front.sv
`default_nettype none
module mbpf_front #(
  parameter int BLOCK_LEN = mbpf_pkg::BLOCK_LEN_DEF,
  parameter int CHANNELS  = mbpf_pkg::CHANNELS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_valid_i,
  output logic                                      s_ready_o,
  input  wire logic [mbpf_pkg::IN_W-1:0]            s_data_i,
  input  wire logic                                 fifo_full_i,
  output logic                                      push_o,
  output logic [CHANNELS-1:0][mbpf_pkg::SAMPLE_W-1:0] push_data_o
);

  localparam int CntW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

  logic [CntW-1:0]                          cnt_q, cnt_d;
  logic [CHANNELS-1:0][mbpf_pkg::SAMPLE_W-1:0] peak_q, peak_d, peak_new;
  logic                                     last_scan;
  logic                                     acc;

  assign last_scan = (cnt_q == CntW'(BLOCK_LEN - 1));
  // only the scan that closes a block needs room in the queue
  assign s_ready_o = !(last_scan && fifo_full_i);
  assign acc       = s_valid_i && s_ready_o;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (s_data_i[c*mbpf_pkg::SAMPLE_W +: mbpf_pkg::SAMPLE_W] > peak_q[c]) begin
        peak_new[c] = s_data_i[c*mbpf_pkg::SAMPLE_W +: mbpf_pkg::SAMPLE_W];
      end else begin
        peak_new[c] = peak_q[c];
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    peak_d = peak_q;
    if (acc) begin
      if (last_scan) begin
        cnt_d  = '0;
        peak_d = '0;
      end else begin
        cnt_d  = cnt_q + CntW'(1);
        peak_d = peak_new;
      end
    end
  end

  assign push_o      = acc && last_scan;
  assign push_data_o = peak_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      peak_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      peak_q <= peak_d;
    end
  end

endmodule
`default_nettype wire

>>> design/mbpf_fifo.sv
`default_nettype none
`include "multichannel_block_peak_framer_macros.svh"
module mbpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mbpf_pkg::FIFO_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `MBPF_ASSERT_IMPL(a_no_overflow, push_i, !full_o || pop_i)
  `MBPF_ASSERT_IMPL(a_no_underflow, pop_i, valid_o)
  `MBPF_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CntW'(DEPTH))

endmodule
`default_nettype wire

>>> design/mbpf_back.sv
`default_nettype none
`include "multichannel_block_peak_framer_macros.svh"
module mbpf_back #(
  parameter int CHANNELS = mbpf_pkg::CHANNELS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [mbpf_pkg::SAMPLE_W-1:0]          cfg_wdata_i,
  input  wire logic                                   fifo_valid_i,
  input  wire logic [CHANNELS-1:0][mbpf_pkg::SAMPLE_W-1:0] fifo_head_i,
  output logic                                        pop_o,
  output logic                                        m_valid_o,
  input  wire logic                                   m_ready_i,
  output logic [mbpf_pkg::BYTE_W-1:0]                 m_data_o,
  output logic                                        m_last_o
);

  localparam int NBytes = 2 + 2 * CHANNELS;
  localparam int IdxW   = $clog2(NBytes);
  localparam int ChW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [mbpf_pkg::SAMPLE_W-1:0] off_q;
  logic [IdxW-1:0]               idx_q, idx_d, rel;
  logic [ChW-1:0]                ch, ch_sel;
  logic [mbpf_pkg::SAMPLE_W-1:0] peak, val;
  logic [mbpf_pkg::BYTE_W-1:0]   byte_d, byte_q;
  logic                          last_d, last_q;
  logic                          out_valid_q, out_valid_d;
  logic                          ld;

  assign ld  = fifo_valid_i && (!out_valid_q || m_ready_i);
  assign rel = idx_q - IdxW'(1);
  assign ch  = rel[ChW:1];
  // header and trailer slots give an out-of-range channel, clamp it
  assign ch_sel = ({1'b0, ch} < (ChW+1)'(CHANNELS)) ? ch : '0;
  assign peak   = fifo_head_i[ch_sel];
  assign val    = (peak > off_q) ? peak - off_q : '0;

  always_comb begin
    last_d = 1'b0;
    if (idx_q == '0) begin
      byte_d = mbpf_pkg::HDR_BYTE;
    end else if (idx_q == IdxW'(NBytes - 1)) begin
      byte_d = mbpf_pkg::TRL_BYTE;
      last_d = 1'b1;
    end else if (!rel[0]) begin
      byte_d = {{(mbpf_pkg::BYTE_W*2 - mbpf_pkg::SAMPLE_W){1'b0}},
                val[mbpf_pkg::SAMPLE_W-1:mbpf_pkg::BYTE_W]};
    end else begin
      byte_d = val[mbpf_pkg::BYTE_W-1:0];
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (ld) begin
      idx_d       = last_d ? '0 : idx_q + IdxW'(1);
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign pop_o     = ld && last_d;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = byte_q;
  assign m_last_o  = last_q;

  always_ff @(posedge clk_i) begin
    if (ld) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= mbpf_pkg::OFFSET_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        off_q <= cfg_wdata_i;
      end
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MBPF_ASSERT_IMPL(a_last_is_trailer, out_valid_q && last_q, byte_q == mbpf_pkg::TRL_BYTE)
  `MBPF_ASSERT_IMPL(a_pop_has_entry, pop_o, fifo_valid_i)
  `MBPF_ASSERT_NEXT(a_frame_restarts, pop_o, idx_q == '0)

endmodule
`default_nettype wire

>>> design/multichannel_block_peak_framer.sv
// multichannel block peak framer
// s_axis carries one scan per transaction: twelve 12-bit samples. the block
// keeps a per-channel running maximum over BLOCK_LEN scans; the scan that
// closes a block queues the peaks, and a frame of 2 + 2*CHANNELS bytes goes
// out on m_axis: header 0x0A, each peak minus the baseline offset (floored at
// zero) as a big-endian 16-bit value, trailer 0x0B with tlast set.
// throughput: one scan per cycle while a closing scan finds room in the queue;
// the frame leaves at one byte per cycle while the receiver is ready, so the
// sustained rate is set by the byte serialiser. the peaks of the closing scan
// are written into the queue, and the header is then loaded from the queue
// into the output register once that register is free.
// a two-entry queue of peak sets sits between accumulation and serialiser;
// when the receiver stalls, scans keep being taken until a closing scan
// finds the queue full, and only that scan waits for room.
// cfg_we_i writes the baseline offset; write it only while the block is idle.
// reset clears peaks, scan count and queue and sets the offset to 3900.
`default_nettype none
module multichannel_block_peak_framer #(
  parameter int BLOCK_LEN = mbpf_pkg::BLOCK_LEN_DEF,
  parameter int CHANNELS  = mbpf_pkg::CHANNELS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbpf_pkg::SAMPLE_W-1:0] cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // sample_ch0, sample_ch1, ... sample_ch11, 12 bits each
  input  wire logic [mbpf_pkg::IN_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // frame_byte
  output logic [mbpf_pkg::BYTE_W-1:0]        m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  logic                                        fifo_full, fifo_valid, push, pop;
  logic [CHANNELS-1:0][mbpf_pkg::SAMPLE_W-1:0] push_data, head;

  mbpf_front #(
    .BLOCK_LEN(BLOCK_LEN),
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .s_data_i   (s_axis_tdata_i),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  mbpf_fifo #(
    .WIDTH(CHANNELS * mbpf_pkg::SAMPLE_W),
    .DEPTH(mbpf_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (fifo_valid),
    .head_o     (head)
  );

  mbpf_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fifo_valid_i(fifo_valid),
    .fifo_head_i (head),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o),
    .m_last_o    (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import mbpf_pkg::*;

  localparam int BLOCK_LEN      = BLOCK_LEN_DEF;
  localparam int CHANNELS       = CHANNELS_DEF;
  localparam int HALF_PERIOD    = 6;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LIMIT_CYCLES   = 200000;

  typedef logic [SAMPLE_W-1:0] samples_t [NUM_IN];

  typedef struct packed {
    logic [BYTE_W-1:0] data_b;
    logic              last_b;
  } frame_beat_t;

  typedef enum int {
    PAT_UNIFORM,
    PAT_NEAR_OFFSET,
    PAT_EXTREMES,
    PAT_LOW
  } scan_pattern_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [SAMPLE_W-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [BYTE_W-1:0] m_axis_tdata_o;
  logic              m_axis_tlast_o;

  // predictor state
  logic [SAMPLE_W-1:0] peak_track [NUM_IN];
  logic [3:0]          scans_in_block;
  logic [SAMPLE_W-1:0] offset_model;
  frame_beat_t         expected_frame_bytes [$];

  int errors = 0;
  int scans_sent = 0;
  int frames_predicted = 0;
  int bytes_checked = 0;
  int offsets_written = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;
  bit idle_en = 1'b1;
  int hold_asked = 0;
  int hold_seen = 0;
  int stall_left = 0;

  multichannel_block_peak_framer #(
    .BLOCK_LEN(BLOCK_LEN),
    .CHANNELS (CHANNELS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (s_axis_tvalid_i && !s_axis_tready_o) begin
      input_stall_cycles++;
    end
  end

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("multichannel_block_peak_framer verification failed");
    $finish;
  end

  // receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      stall_left = HOLDOFF_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // frame byte checker
  always @(posedge clk_i) begin
    frame_beat_t exp_beat;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_frame_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none, actual data %h last %b",
                 $time, m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        exp_beat = expected_frame_bytes.pop_front();
        bytes_checked++;
        if (m_axis_tdata_o !== exp_beat.data_b) begin
          $display("%0t: frame byte mismatch, expected %h actual %h",
                   $time, exp_beat.data_b, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== exp_beat.last_b) begin
          $display("%0t: tlast mismatch, expected %b actual %b",
                   $time, exp_beat.last_b, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  task automatic push_beat(input logic [BYTE_W-1:0] data_b, input logic last_b);
    frame_beat_t beat;
    beat.data_b = data_b;
    beat.last_b = last_b;
    expected_frame_bytes.push_back(beat);
  endtask

  // running maxima over the block; the closing scan yields the whole frame
  task automatic accumulate_scan(input samples_t s);
    logic [15:0] adjusted;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (s[ch] > peak_track[ch]) begin
        peak_track[ch] = s[ch];
      end
    end
    if (int'(scans_in_block) + 1 < BLOCK_LEN) begin
      scans_in_block = scans_in_block + 4'd1;
    end else begin
      push_beat(HDR_BYTE, 1'b0);
      for (int ch = 0; ch < CHANNELS; ch++) begin
        adjusted = (peak_track[ch] > offset_model) ?
                   16'(peak_track[ch] - offset_model) : 16'd0;
        push_beat(adjusted[15:8], 1'b0);
        push_beat(adjusted[7:0], 1'b0);
        peak_track[ch] = '0;
      end
      push_beat(TRL_BYTE, 1'b1);
      scans_in_block = '0;
      frames_predicted++;
    end
  endtask

  function automatic logic [IN_W-1:0] pack_scan(input samples_t s);
    logic [IN_W-1:0] packed_scan;
    for (int ch = 0; ch < NUM_IN; ch++) begin
      packed_scan[ch*SAMPLE_W +: SAMPLE_W] = s[ch];
    end
    return packed_scan;
  endfunction

  function automatic void make_scan(input scan_pattern_e pat, output samples_t s);
    int v;
    for (int ch = 0; ch < NUM_IN; ch++) begin
      case (pat)
        PAT_NEAR_OFFSET: begin
          v = int'(offset_model) + $urandom_range(0, 8) - 4;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          s[ch] = SAMPLE_W'(v);
        end
        PAT_EXTREMES: begin
          s[ch] = $urandom_range(0, 1) ? '1 : '0;
        end
        PAT_LOW: begin
          s[ch] = SAMPLE_W'($urandom_range(0, 63));
        end
        default: begin
          s[ch] = SAMPLE_W'($urandom_range(0, 4095));
        end
      endcase
    end
  endfunction

  // one scan transaction on the input; tvalid stays high for the next call
  task automatic send_scan(input samples_t s);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pack_scan(s);
    do @(posedge clk_i); while (!s_axis_tready_o);
    accumulate_scan(s);
    scans_sent++;
  endtask

  task automatic send_blocks(input int n_blocks);
    samples_t s;
    scan_pattern_e pat;
    for (int b = 0; b < n_blocks; b++) begin
      pat = scan_pattern_e'($urandom_range(0, 3));
      for (int k = 0; k < BLOCK_LEN; k++) begin
        make_scan(pat, s);
        send_scan(s);
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_frame_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [SAMPLE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    offset_model = value;
    offsets_written++;
  endtask

  task automatic test_directed();
    samples_t s;
    logic [SAMPLE_W-1:0] first_scan [NUM_IN] = '{
      12'd4095, 12'd3900, 12'd3901, 12'd0, 12'd4095, 12'd3899,
      12'd2048, 12'd4095, 12'd1, 12'd3950, 12'd4000, 12'd4094
    };
    // reset offset: peaks at, below and just above it, peak set early in the block
    for (int k = 0; k < BLOCK_LEN; k++) begin
      for (int ch = 0; ch < NUM_IN; ch++) begin
        s[ch] = (k == 0) ? first_scan[ch] : '0;
      end
      if (k == 5) s[3] = 12'd3950;
      send_scan(s);
    end
    wait_drained();
    // zero offset: both bytes of the value carry data, channel 0 stays at zero
    write_offset('0);
    for (int k = 0; k < BLOCK_LEN; k++) begin
      for (int ch = 0; ch < NUM_IN; ch++) begin
        if (ch == 0) s[ch] = '0;
        else if (k == 0) s[ch] = 12'hAAA;
        else if (k == BLOCK_LEN - 1) s[ch] = 12'h555;
        else s[ch] = SAMPLE_W'($urandom_range(0, 256));
      end
      if (k == 4) s[11] = 12'hFFF;
      send_scan(s);
    end
    wait_drained();
  endtask

  task automatic test_offset_sweep();
    logic [SAMPLE_W-1:0] offsets [5];
    offsets = '{12'd4095, 12'd1, 12'd2048, 12'd0, SAMPLE_W'($urandom_range(0, 4095))};
    foreach (offsets[i]) begin
      write_offset(offsets[i]);
      send_blocks(2);
      wait_drained();
    end
  endtask

  // output held off long enough for the peak queue to fill and stall the input
  task automatic test_receiver_holdoff();
    idle_en = 1'b0;
    write_offset(OFFSET_RESET);
    hold_asked++;
    send_blocks(3);
    wait_drained();
    idle_en = 1'b1;
  endtask

  // sender stops mid-block until the output has caught up
  task automatic test_sender_pause();
    samples_t s;
    write_offset(SAMPLE_W'($urandom_range(0, 4095)));
    for (int k = 0; k < 3 * BLOCK_LEN; k++) begin
      make_scan(PAT_UNIFORM, s);
      send_scan(s);
      if (k == BLOCK_LEN + 4) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    write_offset(SAMPLE_W'($urandom_range(0, 4095)));
    send_blocks(3);
    wait_drained();
  endtask

  initial begin
    for (int ch = 0; ch < NUM_IN; ch++) peak_track[ch] = '0;
    scans_in_block = '0;
    offset_model = OFFSET_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_offset_sweep();
    test_receiver_holdoff();
    test_sender_pause();
    test_back_to_back();
    repeat (20) @(posedge clk_i);

    $display("scans %0d, frames %0d, bytes checked %0d, offset writes %0d",
             scans_sent, frames_predicted, bytes_checked, offsets_written);
    $display("input stalled for %0d cycles, errors %0d", input_stall_cycles, errors);
    if (errors == 0) begin
      $display("multichannel_block_peak_framer verification clean");
    end else begin
      $display("multichannel_block_peak_framer verification failed");
    end
    $finish;
  end

endmodule
